>>> sv/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, sizes and request codes of the sector cache clock directory.
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int ENTRY_COUNT  = 64;
    localparam int IDX_W        = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int SLOT_W       = 6;
    localparam int SECTOR_W     = 32;
    localparam int RESULT_LIMIT = 64;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [SECTOR_W-1:0] t_sector;
    typedef logic [CNT_W-1:0]    t_cnt;

    localparam t_idx LAST_IDX  = t_idx'(ENTRY_COUNT - 1);
    localparam t_cnt CNT_LIMIT = t_cnt'(RESULT_LIMIT);

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    function automatic t_slot to_slot(t_idx idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[SLOT_W-1:0];
    endfunction

endpackage

>>> sv/scd_if.sv
// ----------------------------------------------------------------------------
// scd_req_if / scd_rsp_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface scd_req_if import scd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    t_sector    sector;

    modport source (output valid, req_type, sector, input ready);
    modport sink (input valid, req_type, sector, output ready);
endinterface

interface scd_rsp_if import scd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_slot   slot;
    logic    hit;
    logic    fill;
    logic    writeback;
    t_sector writeback_sector;
    logic    last;

    modport source (output valid, slot, hit, fill, writeback, writeback_sector, last,
                    input ready);
    modport sink (input valid, slot, hit, fill, writeback, writeback_sector, last,
                  output ready);
endinterface

>>> sv/sector_cache_clock_directory.sv
// ----------------------------------------------------------------------------
// sector_cache_clock_directory
// Directory of a fully associative disk-sector cache with clock replacement.
//
// i_req takes one item at a time (read, write, flush); o_rsp returns results
// through an output register, so a result may wait there while the next item
// is taken. Tag, dirty and reference bits share one synchronous RAM with a
// registered read port; a flip-flop valid vector, cleared by reset, marks
// written entries. No cycle reads and writes the same entry.
// Read or write: the tag scan reads one entry per cycle and stops at the
// first hit. A miss scans all ENTRY_COUNT entries, then the clock hand
// examines one slot per cycle (1 .. ENTRY_COUNT + 1 slots) after a first
// RAM read of the slot under the hand.
// Flush: each entry is read, then checked; results come in ascending slot
// order, last set on the final one.
// Request type 3 is dropped at acceptance with no result.
// Reset: synchronous, active low; clears the valid vector, the hand and the
// channels. A stalled receiver holds the output register; the sequencer waits
// until the register frees before loading the next result.
// ----------------------------------------------------------------------------
module sector_cache_clock_directory import scd_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    scd_req_if.sink        i_req,
    scd_rsp_if.source      o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LK_SCAN,
        S_HIT,
        S_SWEEP,
        S_VICT_OUT,
        S_FL_SCAN,
        S_FL_CHK,
        S_FL_END
    } t_state;

    typedef struct packed {
        t_sector tag;
        logic    dirty;
        logic    referenced;
    } t_entry;

    t_state           r_state;
    t_req             r_req;
    t_sector          r_sector;
    t_idx             r_idx;
    t_idx             r_ridx;
    logic             r_rv;
    logic             r_issue_done;
    t_idx             r_hand;
    t_idx             r_sidx;
    logic             r_srv;
    t_idx             r_victim;
    logic             r_wb;
    t_cnt             r_cnt;
    logic             r_have_pend;
    t_idx             r_pend_idx;
    t_sector          r_pend_tag;
    logic [ENTRY_COUNT-1:0] r_valid;

    logic             r_o_valid;
    t_slot            r_o_slot;
    logic             r_o_hit;
    logic             r_o_fill;
    logic             r_o_wb;
    t_sector          r_o_wbs;
    logic             r_o_last;

    t_entry           entry_mem [ENTRY_COUNT];
    t_entry           r_rdata;

    logic             out_free;
    logic             accept;
    logic             mem_re;
    t_idx             mem_raddr;
    logic             mem_we;
    t_idx             mem_waddr;
    t_entry           mem_wdata;
    logic             lk_match;
    logic             fl_sel;
    logic             sw_take;
    t_idx             hand_next;
    t_idx             sidx_next;

    assign out_free  = !r_o_valid || o_rsp.ready;
    assign accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign lk_match  = r_valid[r_ridx] && (r_rdata.tag == r_sector);
    assign fl_sel    = r_valid[r_idx] && r_rdata.dirty && (r_cnt < CNT_LIMIT);
    assign sw_take   = !r_valid[r_hand] || !r_rdata.referenced;
    assign hand_next = (r_hand == LAST_IDX) ? '0 : r_hand + 1'b1;
    assign sidx_next = (r_sidx == LAST_IDX) ? '0 : r_sidx + 1'b1;

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_idx;
        mem_we    = 1'b0;
        mem_waddr = r_hand;
        mem_wdata = r_rdata;
        case (r_state)
            S_LK_SCAN: mem_re = !r_issue_done && !(r_rv && lk_match);
            S_HIT: begin
                mem_we               = out_free;
                mem_waddr            = r_victim;
                mem_wdata.dirty      = r_rdata.dirty || (r_req == REQ_WRITE);
                mem_wdata.referenced = 1'b1;
            end
            S_SWEEP: begin
                mem_raddr            = r_sidx;
                mem_re               = !(r_srv && sw_take);
                mem_we               = r_srv && !sw_take;
                mem_wdata.referenced = 1'b0;
            end
            S_VICT_OUT: begin
                mem_we               = out_free;
                mem_waddr            = r_victim;
                mem_wdata.tag        = r_sector;
                mem_wdata.dirty      = (r_req == REQ_WRITE);
                mem_wdata.referenced = 1'b1;
            end
            S_FL_SCAN: mem_re = 1'b1;
            S_FL_CHK: begin
                mem_we          = fl_sel && (!r_have_pend || out_free);
                mem_waddr       = r_idx;
                mem_wdata.dirty = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= entry_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_hand       <= '0;
            r_o_valid    <= 1'b0;
            r_rv         <= 1'b0;
            r_srv        <= 1'b0;
            r_issue_done <= 1'b0;
            r_have_pend  <= 1'b0;
            r_cnt        <= '0;
            r_idx        <= '0;
        end else begin
            if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req        <= t_req'(i_req.req_type);
                        r_sector     <= i_req.sector;
                        r_idx        <= '0;
                        r_rv         <= 1'b0;
                        r_issue_done <= 1'b0;
                        r_cnt        <= '0;
                        r_have_pend  <= 1'b0;
                        case (t_req'(i_req.req_type))
                            REQ_READ:  r_state <= S_LK_SCAN;
                            REQ_WRITE: r_state <= S_LK_SCAN;
                            REQ_FLUSH: r_state <= S_FL_SCAN;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_LK_SCAN: begin
                    r_rv   <= !r_issue_done;
                    r_ridx <= r_idx;
                    if (!r_issue_done) begin
                        if (r_idx == LAST_IDX) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (r_rv) begin
                        if (lk_match) begin
                            r_victim <= r_ridx;
                            r_state  <= S_HIT;
                        end else if (r_ridx == LAST_IDX) begin
                            r_sidx  <= r_hand;
                            r_srv   <= 1'b0;
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_HIT: begin
                    if (out_free) begin
                        r_o_valid         <= 1'b1;
                        r_o_slot          <= to_slot(r_victim);
                        r_o_hit           <= 1'b1;
                        r_o_fill          <= 1'b0;
                        r_o_wb            <= 1'b0;
                        r_o_wbs           <= '0;
                        r_o_last          <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                S_SWEEP: begin
                    r_sidx <= sidx_next;
                    r_srv  <= 1'b1;
                    if (r_srv) begin
                        r_hand <= hand_next;
                        if (sw_take) begin
                            r_victim <= r_hand;
                            r_wb     <= r_valid[r_hand] && r_rdata.dirty;
                            r_state  <= S_VICT_OUT;
                        end
                    end
                end
                S_VICT_OUT: begin
                    if (out_free) begin
                        r_o_valid         <= 1'b1;
                        r_o_slot          <= to_slot(r_victim);
                        r_o_hit           <= 1'b0;
                        r_o_fill          <= 1'b1;
                        r_o_wb            <= r_wb;
                        r_o_wbs           <= r_wb ? r_rdata.tag : '0;
                        r_o_last          <= 1'b1;
                        r_valid[r_victim] <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                S_FL_SCAN: begin
                    r_state <= S_FL_CHK;
                end
                S_FL_CHK: begin
                    if (fl_sel) begin
                        if (!r_have_pend || out_free) begin
                            if (r_have_pend) begin
                                r_o_valid <= 1'b1;
                                r_o_slot  <= to_slot(r_pend_idx);
                                r_o_hit   <= 1'b0;
                                r_o_fill  <= 1'b0;
                                r_o_wb    <= 1'b1;
                                r_o_wbs   <= r_pend_tag;
                                r_o_last  <= 1'b0;
                            end
                            r_pend_idx  <= r_idx;
                            r_pend_tag  <= r_rdata.tag;
                            r_have_pend <= 1'b1;
                            r_cnt       <= r_cnt + 1'b1;
                            if (r_idx == LAST_IDX) begin
                                r_state <= S_FL_END;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= S_FL_SCAN;
                            end
                        end
                    end else if (r_idx == LAST_IDX) begin
                        r_state <= S_FL_END;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_FL_SCAN;
                    end
                end
                S_FL_END: begin
                    if (!r_have_pend) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_slot    <= to_slot(r_pend_idx);
                        r_o_hit     <= 1'b0;
                        r_o_fill    <= 1'b0;
                        r_o_wb      <= 1'b1;
                        r_o_wbs     <= r_pend_tag;
                        r_o_last    <= 1'b1;
                        r_have_pend <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid            = r_o_valid;
    assign o_rsp.slot             = r_o_slot;
    assign o_rsp.hit              = r_o_hit;
    assign o_rsp.fill             = r_o_fill;
    assign o_rsp.writeback        = r_o_wb;
    assign o_rsp.writeback_sector = r_o_wbs;
    assign o_rsp.last             = r_o_last;

    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hand <= LAST_IDX)
        else $error("clock hand out of range");

    a_victim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VICT_OUT) |-> !(r_valid[r_victim] && r_rdata.referenced))
        else $error("victim slot is valid and referenced");

    a_flush_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LIMIT)
        else $error("flush result count exceeds limit");

    a_wb_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_hit) |-> (!r_o_fill && !r_o_wb && r_o_last))
        else $error("hit result carries fill or writeback");

endmodule
